// ===== src/htre_pkg.sv =====
// Package with the constants, codes and transaction types of the header table ring.
package htre_pkg;

	// Table geometry and byte accounting.
	localparam int ENTRIES         = 64;
	localparam int MAX_TABLE_BYTES = 65536;
	localparam int ENTRY_OVERHEAD  = 32;

	localparam int PTR_W   = 6;
	localparam int COUNT_W = 7;
	localparam int LEN_W   = 16;
	localparam int BYTES_W = 18;
	localparam int LIMIT_W = 17;
	localparam int TOTAL_W = 32;
	localparam int REQ_W   = 32;

	localparam logic [COUNT_W-1:0] SLOT_LIMIT_RESET = COUNT_W'(ENTRIES);

	// Item kinds.
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_LIMIT  = 2'd2;

	// Result status codes.
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_BAD_IDX = 2'd1;
	localparam logic [1:0] STATUS_NO_SLOT = 2'd2;

	// One input transaction.
	typedef struct packed {
		logic [1:0]         kind;
		logic [LEN_W-1:0]   name_length;
		logic [LEN_W-1:0]   value_length;
		logic [COUNT_W-1:0] rel_index;
		logic [REQ_W-1:0]   new_limit;
	} item_t;

	// One result transaction.
	typedef struct packed {
		logic [1:0]         status;
		logic [PTR_W-1:0]   slot;
		logic [LEN_W-1:0]   found_name_length;
		logic [LEN_W-1:0]   found_value_length;
		logic [BYTES_W-1:0] used_bytes;
		logic [COUNT_W-1:0] held_entries;
		logic [TOTAL_W-1:0] inserts_total;
		logic [LIMIT_W-1:0] limit_bytes;
	} result_t;

endpackage

// ===== src/header_table_ring_eviction_top.sv =====
// Top level of the header table ring: ring bookkeeping, eviction sequencer and length memory.
//
//  Channel   Signals                  Direction  Handshake
//  -------   -----------------------  ---------  ------------------------------------
//  item      start, busy, item        in         accepted when start is high, busy low
//  result    done, result             out        valid for one cycle while done is high
//  config    cfg_we, cfg_wdata        in         written when cfg_we is high
//
// The sequencer checks an accepted item in the check state and registers the result strobe when
// it finishes; each evicted entry adds a pass through the evict state and back, and a lookup adds
// the look state. An oversize insert empties the ring in a single step. Each eviction reads the
// oldest entry's lengths through the registered read port of the length memory. Busy drops with
// the strobe, so a new item may be accepted at the edge that ends the strobe cycle.
// Reset empties the ring, sets the byte limit to zero and the slot limit to 64; the length
// memory is not cleared. The receiver cannot stall, so results never wait.
module header_table_ring_eviction_top import htre_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  item_t              item,
	output logic               done,
	output result_t            result,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_EVICT = 2'd2;
	localparam logic [1:0] ST_LOOK  = 2'd3;

	localparam int MEM_W = 2 * LEN_W;

	// Control state.
	logic [1:0]         state_q, state_d;
	logic [PTR_W-1:0]   newest_q, newest_d;
	logic [PTR_W-1:0]   oldest_q, oldest_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [BYTES_W-1:0] bytes_q, bytes_d;
	logic [LIMIT_W-1:0] limit_q, limit_d;
	logic [TOTAL_W-1:0] total_q, total_d;
	logic [COUNT_W-1:0] slot_limit_q;
	logic               done_q;

	// Captured transaction and derived values.
	item_t              item_q;
	logic [BYTES_W-1:0] cost_q;
	logic [LIMIT_W-1:0] lim_q;
	result_t            result_q, res_d;
	logic               fin;

	// Length memory.
	logic [MEM_W-1:0]   mem [ENTRIES];
	logic [MEM_W-1:0]   rdata_q;
	logic               mem_we;
	logic [PTR_W-1:0]   mem_raddr;

	// Derived combinational values.
	logic [COUNT_W-1:0] cap;
	logic [BYTES_W:0]   bytes_plus_cost;
	logic               need_bytes;
	logic               look_bad;
	logic [PTR_W+1:0]   look_wrap;
	logic [PTR_W-1:0]   look_p;
	logic [BYTES_W-1:0] ev_cost;

	// Next ring position, wrapping at the capacity.
	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p,
		input logic [COUNT_W-1:0] c);
		logic [COUNT_W-1:0] n;
		n = {1'b0, p} + COUNT_W'(1);
		return (n >= c) ? '0 : n[PTR_W-1:0];
	endfunction

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// Capacity is the slot limit clamped to the ring depth.
	assign cap = (slot_limit_q > COUNT_W'(ENTRIES)) ? COUNT_W'(ENTRIES) : slot_limit_q;

	// Byte budget test for an insert.
	assign bytes_plus_cost = {1'b0, bytes_q} + {1'b0, cost_q};
	assign need_bytes      = bytes_plus_cost > (BYTES_W + 1)'(limit_q);

	// Lookup position counted back from the newest entry.
	assign look_bad  = (item_q.rel_index == '0) || (item_q.rel_index > count_q) || (cap == '0);
	assign look_wrap = {2'b00, newest_q} + {1'b0, cap} - {1'b0, item_q.rel_index};
	assign look_p    = ({1'b0, newest_q} >= item_q.rel_index) ?
		PTR_W'({1'b0, newest_q} - item_q.rel_index) : look_wrap[PTR_W-1:0];

	// Cost of the entry being evicted, from the memory read data.
	assign ev_cost = BYTES_W'(rdata_q[MEM_W-1:LEN_W]) + BYTES_W'(rdata_q[LEN_W-1:0])
		+ BYTES_W'(ENTRY_OVERHEAD);

	// Sequencer: check the item, evict one entry at a time, read a looked-up entry, finish.
	always_comb begin
		state_d   = state_q;
		newest_d  = newest_q;
		oldest_d  = oldest_q;
		count_d   = count_q;
		bytes_d   = bytes_q;
		limit_d   = limit_q;
		total_d   = total_q;
		mem_we    = 1'b0;
		mem_raddr = oldest_q;
		fin       = 1'b0;
		res_d     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				case (item_q.kind)
					KIND_INSERT: begin
						if (cost_q > BYTES_W'(limit_q)) begin
							// Oversize entry: the table empties, the insertion still counts.
							oldest_d = newest_q;
							count_d  = '0;
							bytes_d  = '0;
							total_d  = total_q + TOTAL_W'(1);
							fin      = 1'b1;
						end else if ((count_q != '0) && (need_bytes || (count_q >= cap))) begin
							state_d = ST_EVICT;
						end else if (cap == '0) begin
							res_d.status = STATUS_NO_SLOT;
							fin          = 1'b1;
						end else begin
							mem_we     = 1'b1;
							res_d.slot = newest_q;
							newest_d   = next_slot(newest_q, cap);
							count_d    = count_q + COUNT_W'(1);
							bytes_d    = bytes_plus_cost[BYTES_W-1:0];
							total_d    = total_q + TOTAL_W'(1);
							fin        = 1'b1;
						end
					end
					KIND_LOOKUP: begin
						if (look_bad) begin
							res_d.status = STATUS_BAD_IDX;
							fin          = 1'b1;
						end else begin
							mem_raddr = look_p;
							state_d   = ST_LOOK;
						end
					end
					KIND_LIMIT: begin
						if ((count_q != '0) && (bytes_q > BYTES_W'(lim_q))) begin
							state_d = ST_EVICT;
						end else begin
							limit_d = lim_q;
							fin     = 1'b1;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			ST_EVICT: begin
				// The oldest entry's lengths are on the read data now.
				bytes_d  = (ev_cost <= bytes_q) ? (bytes_q - ev_cost) : '0;
				oldest_d = next_slot(oldest_q, cap);
				count_d  = count_q - COUNT_W'(1);
				state_d  = ST_CHECK;
			end
			ST_LOOK: begin
				res_d.slot               = look_p;
				res_d.found_name_length  = rdata_q[MEM_W-1:LEN_W];
				res_d.found_value_length = rdata_q[LEN_W-1:0];
				fin                      = 1'b1;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (fin) begin
			state_d = ST_IDLE;
		end
		res_d.used_bytes    = bytes_d;
		res_d.held_entries  = count_d;
		res_d.inserts_total = total_d;
		res_d.limit_bytes   = limit_d;
	end

	// Control registers; a configuration write empties the ring.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			newest_q     <= '0;
			oldest_q     <= '0;
			count_q      <= '0;
			bytes_q      <= '0;
			limit_q      <= '0;
			total_q      <= '0;
			slot_limit_q <= SLOT_LIMIT_RESET;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			limit_q <= limit_d;
			total_q <= total_d;
			done_q  <= fin;
			if (cfg_we) begin
				slot_limit_q <= cfg_wdata;
				newest_q     <= '0;
				oldest_q     <= '0;
				count_q      <= '0;
				bytes_q      <= '0;
			end else begin
				newest_q <= newest_d;
				oldest_q <= oldest_d;
				count_q  <= count_d;
				bytes_q  <= bytes_d;
			end
		end
	end

	// Transaction capture, cost and clamped limit, and the result register.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_q <= item;
			cost_q <= BYTES_W'(item.name_length) + BYTES_W'(item.value_length)
				+ BYTES_W'(ENTRY_OVERHEAD);
			lim_q  <= (item.new_limit > REQ_W'(MAX_TABLE_BYTES)) ?
				LIMIT_W'(MAX_TABLE_BYTES) : item.new_limit[LIMIT_W-1:0];
		end
		if (fin) begin
			result_q <= res_d;
		end
	end

	// Length memory: one write port at the newest slot, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[newest_q] <= {item_q.name_length, item_q.value_length};
		end
		rdata_q <= mem[mem_raddr];
	end

`ifndef SYNTHESIS
	// The ring never holds more entries than its capacity.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap)
		else $error("entry count exceeds ring capacity");

	// An accepted transaction makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !cfg_we) |=> busy)
		else $error("accepted transaction did not start work");

	// A result strobe only follows a cycle of work.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// The byte limit in force never exceeds the table maximum.
	a_limit_max: assert property (@(posedge clk) disable iff (!arst_n)
		limit_q <= LIMIT_W'(MAX_TABLE_BYTES))
		else $error("byte limit above table maximum");
`endif

endmodule
